FILE: design/adat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adat_pkg
// Shared constants, codes and types for the alert coalescing table.
// ----------------------------------------------------------------------------
package adat_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam logic [11:0] DEDUP_RESET = 12'd60;
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [1:0] ST_MERGED   = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;

  localparam int REC_W = 8 + 32 + 64 + 16 + 2 + 16;

  typedef struct packed {
    logic [7:0]  attack_type;
    logic [31:0] source_ip;
    logic [63:0] first_time;
    logic [15:0] peak_score;
    logic [1:0]  max_severity;
    logic [15:0] count;
  } rec_t;

  typedef struct packed {
    logic load_req;
    logic rd_start;
    logic rd_next;
    logic wr_merge;
    logic wr_insert;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic rd_hit;
    logic rd_old;
    logic scan_end;
    logic full;
    logic empty;
  } stat_t;

endpackage
`default_nettype wire

FILE: design/adat_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adat_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module adat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/adat_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adat_datapath
// Request registers, cutoff, ring pointers, entry memory and compare logic.
// ----------------------------------------------------------------------------
module adat_datapath
  import adat_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,
  input  wire logic [7:0]  attack_type,
  input  wire logic [31:0] source_ip,
  input  wire logic [62:0] time_ns,
  input  wire logic [15:0] score,
  input  wire logic [1:0]  severity,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  output rec_t             rd_rec
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [11:0] dedup_seconds;
  logic [7:0]  req_attack_type;
  logic [31:0] req_source_ip;
  logic [62:0] req_time;
  logic [15:0] req_score;
  logic [1:0]  req_severity;
  logic [41:0] window_ns;
  logic [63:0] cutoff;
  logic [AW-1:0] head;
  logic [CW-1:0] occupancy;
  logic [CW-1:0] scan_idx;
  logic [AW-1:0] rd_slot;
  logic [AW-1:0] rd_slot_q;
  logic [AW-1:0] slot_next;
  logic [AW-1:0] tail_slot;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  rec_t          ram_wdata;
  logic [REC_W-1:0] ram_rdata;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    slot_inc = (s == LAST_SLOT) ? '0 : s + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dedup_seconds <= DEDUP_RESET;
    end else if (cfg_we) begin
      dedup_seconds <= cfg_wdata;
    end
  end

  // The window product is registered before the cutoff subtraction.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_attack_type <= attack_type;
      req_source_ip <= source_ip;
      req_time <= time_ns;
      req_score <= score;
      req_severity <= severity;
      window_ns <= 42'(dedup_seconds * NS_PER_SEC);
    end
    cutoff <= {1'b0, req_time} - {22'd0, window_ns};
  end

  always_comb begin
    tail_slot = head + AW'(occupancy[AW-1:0]);
    if ({1'b0, head} + CW'(occupancy) >= CW'(DEPTH) + (CW + 1)'(0)) begin
      tail_slot = AW'({1'b0, head} + occupancy - FULL_CNT);
    end
    slot_next = slot_inc(rd_slot_q);
    rd_slot = rd_slot_q;
    if (cmd.rd_start) begin
      rd_slot = head;
    end else if (cmd.rd_next) begin
      rd_slot = slot_next;
    end else if (cmd.pop) begin
      rd_slot = slot_inc(head);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occupancy <= '0;
      scan_idx <= '0;
      rd_slot_q <= '0;
    end else begin
      rd_slot_q <= rd_slot;
      if (cmd.rd_start) begin
        scan_idx <= '0;
      end else if (cmd.rd_next) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (cmd.wr_insert) begin
        occupancy <= occupancy + CW'(1);
      end else if (cmd.pop) begin
        occupancy <= occupancy - CW'(1);
        head <= slot_inc(head);
      end
    end
  end

  assign rd_rec = rec_t'(ram_rdata);

  always_comb begin
    ram_we = cmd.wr_merge | cmd.wr_insert;
    ram_waddr = cmd.wr_merge ? rd_slot_q : tail_slot;
    if (cmd.wr_merge) begin
      ram_wdata = rd_rec;
      if (rd_rec.count != 16'hFFFF) begin
        ram_wdata.count = rd_rec.count + 16'd1;
      end
      if (req_score > rd_rec.peak_score) begin
        ram_wdata.peak_score = req_score;
      end
      if (req_severity > rd_rec.max_severity) begin
        ram_wdata.max_severity = req_severity;
      end
    end else begin
      ram_wdata.attack_type = req_attack_type;
      ram_wdata.source_ip = req_source_ip;
      ram_wdata.first_time = {1'b0, req_time};
      ram_wdata.peak_score = req_score;
      ram_wdata.max_severity = req_severity;
      ram_wdata.count = 16'd1;
    end
  end

  adat_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.rd_hit = (rd_rec.attack_type == req_attack_type)
                  && (rd_rec.source_ip == req_source_ip)
                  && ($signed(rd_rec.first_time) >= $signed(cutoff));
    stat.rd_old = $signed(rd_rec.first_time) < $signed(cutoff);
    stat.scan_end = scan_idx >= occupancy;
    stat.full = occupancy >= FULL_CNT;
    stat.empty = occupancy == '0;
  end

  ap_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= FULL_CNT) else $error("occupancy exceeds depth");
  ap_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_insert |-> !stat.full) else $error("insert into full ring");
  ap_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.empty) else $error("pop from empty ring");

endmodule
`default_nettype wire

FILE: design/adat_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adat_ctrl
// Sequencer for the submit scan and the flush pop loop, with result register.
// ----------------------------------------------------------------------------
module adat_ctrl
  import adat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [1:0]       submit_status,
  output logic [7:0]       out_attack_type,
  output logic [31:0]      out_source_ip,
  output logic [1:0]       max_severity,
  output logic [15:0]      peak_score,
  output logic [15:0]      alert_count,
  output logic             last,
  output cmd_t             cmd,
  input  wire stat_t       stat,
  input  wire rec_t        rd_rec
);

  typedef enum logic [2:0] {
    S_IDLE, S_CUT, S_SREAD, S_SCHK, S_FREAD, S_FCHK, S_WAIT
  } state_t;

  state_t state;
  logic   is_flush;
  logic   out_free;
  logic   out_load;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign out_load = out_free && (((state == S_SCHK) && !cmd.rd_next) || (state == S_FCHK));

  always_comb begin
    cmd = '0;
    cmd.load_req = in_valid && in_ready;
    case (state)
      S_CUT:   cmd.rd_start = 1'b1;
      S_SCHK: begin
        if (!stat.scan_end && stat.rd_hit && out_free) begin
          cmd.wr_merge = 1'b1;
        end else if (!stat.scan_end && !stat.rd_hit) begin
          cmd.rd_next = 1'b1;
        end else if (stat.scan_end && !stat.full && out_free) begin
          cmd.wr_insert = 1'b1;
        end
      end
      S_FCHK: begin
        if (!stat.empty && stat.rd_old && out_free) begin
          cmd.pop = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      is_flush <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            is_flush <= req_type;
            state <= S_CUT;
          end
        end
        S_CUT: state <= is_flush ? S_FREAD : S_SREAD;
        S_SREAD: state <= S_SCHK;
        S_SCHK: begin
          if (cmd.rd_next) begin
            state <= S_SREAD;
          end else if (out_free) begin
            out_valid <= 1'b1;
            kind <= KIND_STATUS;
            last <= 1'b1;
            out_attack_type <= '0;
            out_source_ip <= '0;
            max_severity <= '0;
            peak_score <= '0;
            alert_count <= '0;
            submit_status <= cmd.wr_merge ? ST_MERGED :
                             (cmd.wr_insert ? ST_INSERTED : ST_DROPPED);
            state <= S_WAIT;
          end
        end
        S_FREAD: state <= S_FCHK;
        S_FCHK: begin
          if (out_free) begin
            out_valid <= 1'b1;
            submit_status <= ST_MERGED;
            if (cmd.pop) begin
              kind <= KIND_RECORD;
              last <= 1'b0;
              out_attack_type <= rd_rec.attack_type;
              out_source_ip <= rd_rec.source_ip;
              max_severity <= rd_rec.max_severity;
              peak_score <= rd_rec.peak_score;
              alert_count <= rd_rec.count;
              state <= S_FREAD;
            end else begin
              kind <= KIND_DONE;
              last <= 1'b1;
              out_attack_type <= '0;
              out_source_ip <= '0;
              max_severity <= '0;
              peak_score <= '0;
              alert_count <= '0;
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_one_write: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.wr_merge, cmd.wr_insert, cmd.pop}) <= 1)
    else $error("conflicting table updates");
  ap_pop_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> out_valid && kind == KIND_RECORD)
    else $error("pop without record");
  ap_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !cmd.pop && !cmd.wr_insert && !cmd.wr_merge)
    else $error("table update while idle");

endmodule
`default_nettype wire

FILE: design/alert_dedup_aggregation_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alert_dedup_aggregation_table
// Alert coalescing table kept as a ring of aggregated records.
// ----------------------------------------------------------------------------
// Requests arrive on the in_valid/in_ready channel; req_type 0 submits an
// alert and req_type 1 flushes aged records at the given time. Results
// leave on out_valid/out_ready, one transfer each, with last set on the
// final result of a request. A submit yields one status result, a flush
// yields one record per aged entry popped from the head of the ring, up to
// the first entry that is not aged, and then a done result. The entry store
// is one RAM with registered read, so each step of the ring walk has a read
// state and then a check state. After the final result is loaded the
// sequencer passes through S_WAIT to S_IDLE before it takes the next request.
// One request is handled at a time; in_ready is high only when idle. When
// the receiver stalls the sequencer holds in its check state, once it has a
// result to load, until the result register frees. Reset empties the ring
// and sets the window to 60 seconds. The user must write dedup_seconds
// through cfg_we/cfg_wdata only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module alert_dedup_aggregation_table
  import adat_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [7:0]  attack_type,
  input  wire logic [31:0] source_ip,
  input  wire logic [62:0] time_ns,
  input  wire logic [15:0] score,
  input  wire logic [1:0]  severity,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [1:0]       submit_status,
  output logic [7:0]       out_attack_type,
  output logic [31:0]      out_source_ip,
  output logic [1:0]       max_severity,
  output logic [15:0]      peak_score,
  output logic [15:0]      alert_count,
  output logic             last
);

  cmd_t  cmd;
  stat_t stat;
  rec_t  rd_rec;

  adat_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .req_type, .out_valid, .out_ready,
    .kind, .submit_status, .out_attack_type, .out_source_ip, .max_severity,
    .peak_score, .alert_count, .last, .cmd, .stat, .rd_rec
  );

  adat_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst, .cfg_we, .cfg_wdata, .attack_type, .source_ip, .time_ns,
    .score, .severity, .cmd, .stat, .rd_rec
  );

endmodule
`default_nettype wire

FILE: tb/tb_checker.sv
// ----------------------------------------------------------------------------
// Alert table result checker
// Watches the request and result channels of the alert coalescing table,
// keeps its own copy of the ring, and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_checker
  import adat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        req_type,
  input  wire logic [7:0]  attack_type,
  input  wire logic [31:0] source_ip,
  input  wire logic [62:0] time_ns,
  input  wire logic [15:0] score,
  input  wire logic [1:0]  severity,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [1:0]  submit_status,
  input  wire logic [7:0]  out_attack_type,
  input  wire logic [31:0] out_source_ip,
  input  wire logic [1:0]  max_severity,
  input  wire logic [15:0] peak_score,
  input  wire logic [15:0] alert_count,
  input  wire logic        last,
  output int               fail_count,
  output int               pending
);

  localparam int SLOTS = DEFAULT_DEPTH;
  localparam int QDEPTH = 64;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [7:0]  atype;
    logic [31:0] ip;
    logic [1:0]  sev;
    logic [15:0] score;
    logic [15:0] count;
    logic        last;
  } result_t;

  rec_t      ring [SLOTS];
  int        head;
  int        occupancy;
  logic [11:0] window_sec;
  result_t   exp_fifo [QDEPTH];
  int        exp_wr;
  int        exp_rd;

  function automatic result_t make_result(logic [1:0] k, logic [1:0] st,
                                          rec_t r, logic lst);
    result_t x;
    x.kind = k;
    x.status = st;
    x.atype = r.attack_type;
    x.ip = r.source_ip;
    x.sev = r.max_severity;
    x.score = r.peak_score;
    x.count = r.count;
    x.last = lst;
    return x;
  endfunction

  function automatic void enqueue(result_t x);
    exp_fifo[exp_wr % QDEPTH] = x;
    exp_wr++;
  endfunction

  task automatic predict_request();
    longint cutoff;
    rec_t   blank;
    rec_t   r;
    int     s;
    bit     merged;
    blank = '0;
    merged = 0;
    cutoff = longint'({1'b0, time_ns}) - longint'(window_sec) * 64'sd1000000000;
    if (req_type == 1'b0) begin
      for (int i = 0; i < occupancy && !merged; i++) begin
        s = (head + i) % SLOTS;
        r = ring[s];
        if (r.attack_type == attack_type && r.source_ip == source_ip &&
            $signed(r.first_time) >= cutoff) begin
          if (r.count != 16'hffff) r.count++;
          if (score > r.peak_score) r.peak_score = score;
          if (severity > r.max_severity) r.max_severity = severity;
          ring[s] = r;
          merged = 1;
        end
      end
      if (merged) begin
        enqueue(make_result(KIND_STATUS, ST_MERGED, blank, 1'b1));
      end else if (occupancy >= SLOTS) begin
        enqueue(make_result(KIND_STATUS, ST_DROPPED, blank, 1'b1));
      end else begin
        r.attack_type = attack_type;
        r.source_ip = source_ip;
        r.first_time = {1'b0, time_ns};
        r.peak_score = score;
        r.max_severity = severity;
        r.count = 16'd1;
        ring[(head + occupancy) % SLOTS] = r;
        occupancy++;
        enqueue(make_result(KIND_STATUS, ST_INSERTED, blank, 1'b1));
      end
    end else begin
      while (occupancy > 0 && $signed(ring[head].first_time) < cutoff) begin
        enqueue(make_result(KIND_RECORD, ST_MERGED, ring[head], 1'b0));
        head = (head + 1) % SLOTS;
        occupancy--;
      end
      enqueue(make_result(KIND_DONE, ST_MERGED, blank, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      head = 0;
      occupancy = 0;
      window_sec = DEDUP_RESET;
      fail_count = 0;
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      if (cfg_we) window_sec = cfg_wdata;
      if (out_valid && out_ready) begin
        got.kind = kind;
        got.status = submit_status;
        got.atype = out_attack_type;
        got.ip = out_source_ip;
        got.sev = max_severity;
        got.score = peak_score;
        got.count = alert_count;
        got.last = last;
        if (exp_wr == exp_rd) begin
          if (fail_count < 10) $display("unexpected result transfer %p", got);
          fail_count = fail_count + 1;
        end else begin
          want = exp_fifo[exp_rd % QDEPTH];
          exp_rd++;
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) predict_request();
    end
    pending = exp_wr - exp_rd;
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Alert table testbench
// Drives directed and random submits and flushes with random idling on
// both channels, changes the window between phases, and reports a verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import adat_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [11:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [7:0]  attack_type;
  logic [31:0] source_ip;
  logic [62:0] time_ns;
  logic [15:0] score;
  logic [1:0]  severity;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [1:0]  submit_status;
  logic [7:0]  out_attack_type;
  logic [31:0] out_source_ip;
  logic [1:0]  max_severity;
  logic [15:0] peak_score;
  logic [15:0] alert_count;
  logic        last;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          calm;
  longint      clock_ns;

  localparam int CYCLE_LIMIT = 400000;
  localparam longint SEC = 64'd1000000000;

  alert_dedup_aggregation_table u_top (.*);

  tb_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : sink
    int n;
    out_ready = 0;
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 19);
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  task automatic send_request(logic rt, logic [7:0] at, logic [31:0] ip,
                              logic [62:0] t, logic [15:0] sc, logic [1:0] sv);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 19);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= rt;
    attack_type <= at;
    source_ip <= ip;
    time_ns <= t;
    score <= sc;
    severity <= sv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_window(logic [11:0] sec);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= sec;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(int items, int keys);
    for (int i = 0; i < items; i++) begin
      clock_ns += longint'($urandom_range(0, 40)) * SEC / 4;
      if ($urandom_range(0, 7) == 0) begin
        send_request(1'b1, 8'($urandom), $urandom, 63'(clock_ns), 16'($urandom),
                     2'($urandom));
      end else begin
        send_request(1'b0, 8'($urandom_range(0, keys)), 32'($urandom_range(0, keys)),
                     63'(clock_ns - longint'($urandom_range(0, 20)) * SEC),
                     16'($urandom), 2'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    in_valid = 0;
    req_type = 0;
    attack_type = 0;
    source_ip = 0;
    time_ns = 0;
    score = 0;
    severity = 0;
    calm = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_request(1'b0, 8'hff, 32'hffffffff, 63'd50, 16'hffff, 2'd3);
    send_request(1'b0, 8'hff, 32'hffffffff, 63'd50, 16'd0, 2'd0);
    send_request(1'b0, 8'h00, 32'h0, 63'd0, 16'd0, 2'd0);
    send_request(1'b0, 8'h00, 32'h0, 63'd5, 16'd9, 2'd1);
    for (int i = 0; i < 14; i++)
      send_request(1'b0, 8'(i + 1), 32'hdeadbeef, 63'd100, 16'(i), 2'(i));
    send_request(1'b0, 8'h00, 32'h0, 63'd10, 16'd3, 2'd2);
    send_request(1'b0, 8'h55, 32'h1, 63'd10, 16'd7, 2'd1);
    send_request(1'b1, 8'h00, 32'h0, 63'd0, 16'd0, 2'd0);
    send_request(1'b1, 8'h00, 32'h0, 63'(200 + 60 * SEC), 16'd0, 2'd0);
    send_request(1'b1, 8'hff, 32'hffffffff, 63'h7fffffffffffffff, 16'hffff, 2'd3);

    write_window(12'd0);
    clock_ns = 0;
    random_phase(25, 3);
    send_request(1'b1, 8'h0, 32'h0, 63'(clock_ns + SEC), 16'd0, 2'd0);
    write_window(12'd3600);
    random_phase(25, 2);
    send_request(1'b1, 8'h0, 32'h0, 63'(clock_ns + 3601 * SEC), 16'd0, 2'd0);
    write_window(12'd5);
    random_phase(25, 4);
    calm = 1;
    write_window(12'd4095);
    random_phase(25, 3);
    send_request(1'b1, 8'h0, 32'h0, 63'h7fffffffffffffff, 16'd0, 2'd0);

    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
